// ===== rtl/core/ilid_pkg.sv =====
package ilid_pkg;

  // Field widths fixed by the item format
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Broadcast from the control to every cell of the chain
  typedef struct packed {
    logic             insert_go;
    logic             delete_go;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ilid_cell.sv =====
module ilid_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  ilid_pkg::cell_ctrl_t            ctrl,
  input  logic signed [ilid_pkg::DATA_W-1:0] left,
  input  logic signed [ilid_pkg::DATA_W-1:0] right,
  input  logic signed [ilid_pkg::DATA_W-1:0] value,
  output logic signed [ilid_pkg::DATA_W-1:0] entry,
  output logic signed [ilid_pkg::DATA_W-1:0] tap
);
  import ilid_pkg::*;

  logic above;
  logic here;

  assign above = int'(ctrl.pos) < IDX;
  assign here  = int'(ctrl.pos) == IDX;

  // Shift up from the lower neighbour on insert, down from the upper one on delete
  always_ff @(posedge clk) begin
    if (ctrl.insert_go) begin
      if (above) begin
        entry <= left;
      end else if (here) begin
        entry <= value;
      end
    end else if (ctrl.delete_go && (above || here)) begin
      entry <= right;
    end
  end

  // Offer the entry to the read bus only at the addressed position
  assign tap = here ? entry : '0;

endmodule

// ===== rtl/core/indexed_list_insert_delete_top.sv =====
// One item per cycle while no result is stalled; a result beat is registered and
// appears in the cycle after its input is accepted. Only the entry cells at and above the
// position update on accept; the read ORs the cell taps into the output register.
// Reset (rst, synchronous, active high) clears the count and the output valid;
// entry contents are left as they are and only entries below the count are read.
module indexed_list_insert_delete_top #(
  parameter int CAPACITY = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ilid_pkg::FUNC_W-1:0]         func,
  input  logic [ilid_pkg::POS_W-1:0]          position,
  input  logic signed [ilid_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ilid_pkg::STAT_W-1:0]         status,
  output logic signed [ilid_pkg::DATA_W-1:0]  read_value,
  output logic [ilid_pkg::COUNT_W-1:0]        count_after
);
  import ilid_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       accept;
  logic [CMPW-1:0]            pos_w;
  logic [CMPW-1:0]            cnt_w;
  logic                       full;
  logic                       ins_ok;
  logic                       del_ok;
  logic                       rd_ok;
  logic [STAT_W-1:0]          status_next;
  logic signed [DATA_W-1:0]   rd_bus;
  cell_ctrl_t                 ctrl;
  logic signed [DATA_W-1:0]   entry [CAPACITY];
  logic signed [DATA_W-1:0]   tap   [CAPACITY];

  // Hold intake while a finished result is still waiting
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Decode the operation against the current count
  assign pos_w  = CMPW'(position);
  assign cnt_w  = CMPW'(count);
  assign full   = count == CW'(CAPACITY);
  assign ins_ok = (func == OP_INSERT) && !full && (pos_w <= cnt_w);
  assign del_ok = (func == OP_DELETE) && (pos_w < cnt_w);
  assign rd_ok  = (func == OP_READ) && (pos_w < cnt_w);

  always_comb begin
    case (func)
      OP_INSERT: status_next = full ? ST_FULL : (ins_ok ? ST_OK : ST_RANGE);
      OP_DELETE: status_next = del_ok ? ST_OK : ST_RANGE;
      OP_READ:   status_next = rd_ok ? ST_OK : ST_RANGE;
      default:   status_next = ST_RANGE;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CW'(1);
    end else if (del_ok) begin
      count_next = count - CW'(1);
    end
  end

  // Broadcast the operation to the chain
  assign ctrl.insert_go = accept && ins_ok;
  assign ctrl.delete_go = accept && del_ok;
  assign ctrl.pos       = position;

  // Chain of entry cells, each fed by its neighbours (an end cell by itself on its open side)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = entry[i];
    end else begin : g_mid_lo
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_mid_hi
      assign right = entry[i+1];
    end
    ilid_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .value (value),
      .entry (entry[i]),
      .tap   (tap[i])
    );
  end

  // Gather the addressed entry from the cell taps
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | tap[i];
    end
  end

  // Advance the count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register: drop the beat when taken, load on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      read_value  <= rd_ok ? rd_bus : '0;
      count_after <= COUNT_W'(count_next);
    end
  end

endmodule

// ===== rtl/core/ilid_checker.sv =====
module ilid_assert (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ilid_pkg::STAT_W-1:0]         status,
  input logic signed [ilid_pkg::DATA_W-1:0]  read_value,
  input logic [ilid_pkg::COUNT_W-1:0]        count_after
);
  import ilid_pkg::*;

  // An accepted beat always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after accepted beat");

  // Intake is held while a result waits
  a_hold_intake: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result stalled");

  // Only a successful operation may carry a non-zero read value
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_value == '0))
    else $error("read value on failed operation");

  // Status code is always one of the defined outcomes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
    else $error("undefined status");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(read_value) && $stable(count_after)))
    else $error("stalled result changed");

endmodule

bind indexed_list_insert_delete_top ilid_assert u_ilid_assert (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .read_value  (read_value),
  .count_after (count_after)
);
